// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// cond must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// File: hdl/lpbue_pkg.sv
// ---------------------------------------------------------------------------
// lpbue_pkg
// Types and constants shared by the LED brightness buffer update engine.
// ---------------------------------------------------------------------------
package lpbue_pkg;

  localparam int FUNC_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int SUM_W   = 16;
  localparam int CUR_W   = 10;

  // current = floor(sum * (64700/18) / (256*1000))
  // 256000 = 2^11 * 125; the /125 is a multiply by ceil(2^24/125), exact
  // for inputs below 2^24/34.
  localparam int CUR_FACTOR  = 64700 / 18;
  localparam int CUR_DIVISOR = 256 * 1000;
  localparam int CUR_SHIFT   = 11;
  localparam int CUR_ODD     = CUR_DIVISOR / (1 << CUR_SHIFT);
  localparam int RECIP_SHIFT = 24;
  localparam int CUR_RECIP   = (1 << RECIP_SHIFT) / CUR_ODD + 1;
  localparam int PROD_W      = 28;
  localparam int QIN_W       = PROD_W - CUR_SHIFT;
  localparam int RECIP_W     = 18;
  localparam int QUO_W       = QIN_W + RECIP_W;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    F_DEC_ONE = 4'd0,
    F_INC_ONE = 4'd1,
    F_SET_ONE = 4'd2,
    F_SET_ALL = 4'd3,
    F_SET_CMD = 4'd4,
    F_SET_STO = 4'd5,
    F_DEC_ALL = 4'd6,
    F_INC_ALL = 4'd7,
    F_DEC_STO = 4'd8,
    F_INC_STO = 4'd9,
    F_DEC_CMD = 4'd10,
    F_INC_CMD = 4'd11,
    F_LD_CMD  = 4'd12,
    F_LD_STO  = 4'd13
  } func_t;

  typedef enum logic [1:0] {
    K_SET,
    K_ADD,
    K_SUB
  } kind_t;

  typedef enum logic [2:0] {
    M_NONE,
    M_ONE,
    M_ALL,
    M_CMD,
    M_STO,
    M_LD_CMD,
    M_LD_STO
  } mode_t;

  typedef struct packed {
    mode_t               mode;
    kind_t               kind;
    logic [BYTE_W-1:0]   first;   // channel, or mask byte number for loads
    logic [BYTE_W-1:0]   last;
    logic [BYTE_W-1:0]   amount;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic busy;
    logic wr;
  } bk_stat_t;

endpackage

// File: hdl/lpbue_ram.sv
// ---------------------------------------------------------------------------
// lpbue_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module lpbue_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 144
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: hdl/lpbue_front.sv
// ---------------------------------------------------------------------------
// lpbue_front
// Accepts command words, range-checks and classifies them into queue entries.
// ---------------------------------------------------------------------------
module lpbue_front #(
  parameter int CHANNELS   = 144,
  parameter int MASK_BYTES = 18
) (
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [23:0]                in_tdata,   // func[3:0], index[11:4], amount[19:12]
  input  lpbue_pkg::q_stat_t         q_stat,
  output logic                       q_push,
  output lpbue_pkg::cmd_t            q_cmd
);
  import lpbue_pkg::*;

  logic [FUNC_W-1:0] func;
  logic [BYTE_W-1:0] idx;
  logic [BYTE_W-1:0] amount;
  logic              ch_ok;
  logic              mb_ok;

  assign func   = in_tdata[3:0];
  assign idx    = in_tdata[11:4];
  assign amount = in_tdata[19:12];

  assign ch_ok = {1'b0, idx} < 9'(CHANNELS);
  assign mb_ok = {1'b0, idx} < 9'(MASK_BYTES);

  assign in_tready = !q_stat.full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    q_cmd        = '0;
    q_cmd.amount = amount;
    q_cmd.first  = '0;
    q_cmd.last   = BYTE_W'(CHANNELS - 1);
    q_cmd.kind   = K_SET;
    q_cmd.mode   = M_NONE;
    unique case (func)
      F_DEC_ONE, F_INC_ONE, F_SET_ONE: begin
        q_cmd.first = idx;
        q_cmd.last  = idx;
        q_cmd.mode  = ch_ok ? M_ONE : M_NONE;
        q_cmd.kind  = (func == F_DEC_ONE) ? K_SUB :
                      (func == F_INC_ONE) ? K_ADD : K_SET;
      end
      F_SET_ALL: begin q_cmd.mode = M_ALL; q_cmd.kind = K_SET; end
      F_DEC_ALL: begin q_cmd.mode = M_ALL; q_cmd.kind = K_SUB; end
      F_INC_ALL: begin q_cmd.mode = M_ALL; q_cmd.kind = K_ADD; end
      F_SET_CMD: begin q_cmd.mode = M_CMD; q_cmd.kind = K_SET; end
      F_DEC_CMD: begin q_cmd.mode = M_CMD; q_cmd.kind = K_SUB; end
      F_INC_CMD: begin q_cmd.mode = M_CMD; q_cmd.kind = K_ADD; end
      F_SET_STO: begin q_cmd.mode = M_STO; q_cmd.kind = K_SET; end
      F_DEC_STO: begin q_cmd.mode = M_STO; q_cmd.kind = K_SUB; end
      F_INC_STO: begin q_cmd.mode = M_STO; q_cmd.kind = K_ADD; end
      F_LD_CMD: begin
        q_cmd.first = idx;
        q_cmd.mode  = mb_ok ? M_LD_CMD : M_NONE;
      end
      F_LD_STO: begin
        q_cmd.first = idx;
        q_cmd.mode  = mb_ok ? M_LD_STO : M_NONE;
      end
      default: q_cmd.mode = M_NONE;
    endcase
  end

endmodule

// File: hdl/lpbue_queue.sv
// ---------------------------------------------------------------------------
// lpbue_queue
// Short command queue between the front and back ends.
// ---------------------------------------------------------------------------
module lpbue_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lpbue_pkg::cmd_t    push_cmd,
  input  logic               pop,
  output lpbue_pkg::cmd_t    pop_cmd,
  output lpbue_pkg::q_stat_t stat
);
  import lpbue_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign pop_cmd    = mem_r[rd_ptr_r];
  assign stat.full  = count_r == QCNT_W'(QDEPTH);
  assign stat.empty = count_r == '0;
  assign stat.count = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: hdl/lpbue_back.sv
// ---------------------------------------------------------------------------
// lpbue_back
// Executes queued commands: channel sweep over the brightness RAM, mask
// loads, running sum upkeep and the current estimate.
// ---------------------------------------------------------------------------
module lpbue_back #(
  parameter int CHANNELS   = 144,
  parameter int MASK_BYTES = 18
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpbue_pkg::cmd_t     q_cmd,
  input  lpbue_pkg::q_stat_t  q_stat,
  output logic                q_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // brightness_sum[15:0], current_estimate[25:16]
  output lpbue_pkg::bk_stat_t stat
);
  import lpbue_pkg::*;

  localparam int AW   = $clog2(CHANNELS);
  localparam int MB_W = (MASK_BYTES > 1) ? $clog2(MASK_BYTES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_t;

  state_t             state_r;
  cmd_t               cmd_r;
  logic               iss_act_r;
  logic [BYTE_W-1:0]  iss_ch_r;
  logic               pend_r;
  logic [AW-1:0]      pend_ch_r;
  logic               pend_sel_r;
  logic               pend_vld_r;
  logic [CHANNELS-1:0] valid_r;
  logic [BYTE_W-1:0]  cmd_mask_r [MASK_BYTES];
  logic [BYTE_W-1:0]  sto_mask_r [MASK_BYTES];
  logic [SUM_W-1:0]   sum_r;
  logic [PROD_W-1:0]  prod_r;
  logic [QUO_W-1:0]   quo_r;
  logic               out_valid_r;
  logic [SUM_W-1:0]   out_sum_r;
  logic [CUR_W-1:0]   out_cur_r;

  logic [4:0]         byte_no;
  logic               byte_ok;
  logic [MB_W-1:0]    mb;
  logic               iss_sel;
  logic [BYTE_W-1:0]  old_val;
  logic [BYTE_W-1:0]  new_val;
  logic               ram_we;
  logic               ram_re;
  logic [BYTE_W-1:0]  ram_rdata;
  logic [SUM_W-1:0]   sum_nxt;

  // channel c sits at bit (c mod 8) of mask byte (c / 8)
  assign byte_no = iss_ch_r[7:3];
  assign byte_ok = {1'b0, byte_no} < 6'(MASK_BYTES);
  assign mb      = byte_no[MB_W-1:0];

  always_comb begin
    unique case (cmd_r.mode)
      M_ONE, M_ALL: iss_sel = 1'b1;
      M_CMD:        iss_sel = byte_ok && cmd_mask_r[mb][iss_ch_r[2:0]];
      M_STO:        iss_sel = byte_ok && sto_mask_r[mb][iss_ch_r[2:0]];
      default:      iss_sel = 1'b0;
    endcase
  end

  // entries never written read as zero
  assign old_val = pend_vld_r ? ram_rdata : '0;

  always_comb begin
    case (cmd_r.kind)
      K_ADD:   new_val = old_val + cmd_r.amount;
      K_SUB:   new_val = old_val - cmd_r.amount;
      default: new_val = cmd_r.amount;
    endcase
  end

  assign sum_nxt = sum_r - SUM_W'(old_val) + SUM_W'(new_val);
  assign ram_we  = (state_r == S_SWEEP) && pend_r && pend_sel_r;
  assign ram_re  = (state_r == S_SWEEP) && iss_act_r;
  assign q_pop   = (state_r == S_IDLE) && !q_stat.empty;

  lpbue_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_ch_r),
    .wdata (new_val),
    .re    (ram_re),
    .raddr (iss_ch_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_act_r   <= 1'b0;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MASK_BYTES; i++) begin
        cmd_mask_r[i] <= '0;
        sto_mask_r[i] <= '0;
      end
    end else begin
      // S_OUT handles its own handoff of the output word
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_stat.empty) begin
            cmd_r     <= q_cmd;
            iss_ch_r  <= q_cmd.first;
            iss_act_r <= 1'b1;
            pend_r    <= 1'b0;
            case (q_cmd.mode)
              M_LD_CMD: begin
                cmd_mask_r[q_cmd.first[MB_W-1:0]] <= q_cmd.amount;
                state_r <= S_MUL1;
              end
              M_LD_STO: begin
                sto_mask_r[q_cmd.first[MB_W-1:0]] <= q_cmd.amount;
                state_r <= S_MUL1;
              end
              M_NONE:  state_r <= S_MUL1;
              default: state_r <= S_SWEEP;
            endcase
          end
        end
        S_SWEEP: begin
          // read channel n while writing back channel n-1
          if (iss_act_r) begin
            pend_r     <= 1'b1;
            pend_ch_r  <= iss_ch_r[AW-1:0];
            pend_sel_r <= iss_sel;
            pend_vld_r <= valid_r[iss_ch_r[AW-1:0]];
            if (iss_ch_r == cmd_r.last) begin
              iss_act_r <= 1'b0;
            end else begin
              iss_ch_r <= iss_ch_r + 1'b1;
            end
          end else begin
            pend_r <= 1'b0;
          end
          if (pend_r && pend_sel_r) begin
            valid_r[pend_ch_r] <= 1'b1;
            sum_r              <= sum_nxt;
          end
          if (!iss_act_r && !pend_r) begin
            state_r <= S_MUL1;
          end
        end
        S_MUL1: begin
          prod_r  <= PROD_W'(sum_r) * PROD_W'(CUR_FACTOR);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          quo_r   <= QUO_W'(prod_r[PROD_W-1:CUR_SHIFT]) * QUO_W'(CUR_RECIP);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_sum_r   <= sum_r;
            out_cur_r   <= quo_r[RECIP_SHIFT +: CUR_W];
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_cur_r, out_sum_r};
  assign stat.busy  = state_r != S_IDLE;
  assign stat.wr    = ram_we;

endmodule

// File: hdl/led_pwm_buffer_update_engine.sv
// ---------------------------------------------------------------------------
// led_pwm_buffer_update_engine
// Brightness buffer with single, global and masked update commands.
// ---------------------------------------------------------------------------
// Each input word is one command; each command returns exactly one output word
// with the brightness sum and the current estimate. Single-channel commands
// read and write back one RAM entry; mask loads and no-op codes skip the RAM;
// whole-buffer and masked commands sweep every channel through the brightness
// RAM, one channel per cycle. The RAM's single read-modify-write stream sets
// that rate. A two-entry queue lets commands be taken while the back end is
// busy or a result waits to be taken. No clearing pass after reset: per-channel
// valid bits make unwritten channels read zero.
`include "assert_macros.svh"

module led_pwm_buffer_update_engine #(
  parameter int CHANNELS   = 144,
  parameter int MASK_BYTES = 18
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,    // func[3:0], index[11:4], amount[19:12]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata    // brightness_sum[15:0], current_estimate[25:16]
);
  import lpbue_pkg::*;

  q_stat_t  q_stat;
  bk_stat_t bk_stat;
  cmd_t     push_cmd;
  cmd_t     pop_cmd;
  logic     q_push;
  logic     q_pop;

  lpbue_front #(
    .CHANNELS   (CHANNELS),
    .MASK_BYTES (MASK_BYTES)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  lpbue_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  lpbue_back #(
    .CHANNELS   (CHANNELS),
    .MASK_BYTES (MASK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_cmd      (pop_cmd),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (bk_stat)
  );

  `ASSERT_NEVER(a_q_bound, clk, rst_n, q_stat.count > QCNT_W'(QDEPTH))
  `ASSERT_NEVER(a_wr_when_idle, clk, rst_n, bk_stat.wr && !bk_stat.busy)
  `ASSERT_CLK(a_out_from_work, clk, rst_n, $rose(out_tvalid) |-> $past(bk_stat.busy))

endmodule

// File: test/led_pwm_buffer_update_engine_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// led_pwm_buffer_update_engine_tb
// Self-checking bench for the LED brightness buffer update engine. Streams
// single-channel, whole-buffer, masked and mask-load commands. Keeps its own
// copy of the channel levels and both masks, and compares every sum/current
// word in order. Both stream sides get random idle bursts.
// ---------------------------------------------------------------------------
module led_pwm_buffer_update_engine_tb;
  import lpbue_pkg::*;

  localparam int NUM_CH       = 144;
  localparam int NUM_MB       = 18;
  localparam int MA_NUM       = 64700 / 18;
  localparam int MA_DEN       = 256 * 1000;
  localparam int DRAIN_CYCLES = 200;

  // codes the engine treats as no-ops
  localparam logic [FUNC_W-1:0] F_SPARE_LO = 4'd14;
  localparam logic [FUNC_W-1:0] F_SPARE_HI = 4'd15;

  typedef enum {GRP_ALL, GRP_CMD, GRP_STO} group_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CUR_W-1:0] cur;
  } totals_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;    // func[3:0], index[11:4], amount[19:12]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // brightness_sum[15:0], current_estimate[25:16]

  logic [7:0] chan_level    [NUM_CH];
  logic [7:0] cmd_mask_copy [NUM_MB];
  logic [7:0] sto_mask_copy [NUM_MB];
  totals_t    pending_totals[$];

  bit idle_on;
  int out_stall = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_errors  = 0;
  int op_hits[16];

  led_pwm_buffer_update_engine #(
    .CHANNELS  (NUM_CH),
    .MASK_BYTES(NUM_MB)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Brightness predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_levels();
    foreach (chan_level[ch]) chan_level[ch] = '0;
    foreach (cmd_mask_copy[b]) begin
      cmd_mask_copy[b] = '0;
      sto_mask_copy[b] = '0;
    end
    foreach (op_hits[i]) op_hits[i] = 0;
  endfunction

  function automatic bit chan_selected(group_t g, int ch);
    logic [7:0] mb;
    if (g == GRP_ALL) return 1'b1;
    if ((ch >> 3) >= NUM_MB) return 1'b0;
    mb = (g == GRP_CMD) ? cmd_mask_copy[ch >> 3] : sto_mask_copy[ch >> 3];
    return mb[ch & 7];
  endfunction

  function automatic void sweep_levels(group_t g, kind_t k, logic [7:0] amt);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (chan_selected(g, ch)) begin
        case (k)
          K_SET:   chan_level[ch] = amt;
          K_ADD:   chan_level[ch] = chan_level[ch] + amt;
          default: chan_level[ch] = chan_level[ch] - amt;
        endcase
      end
    end
  endfunction

  function automatic totals_t predict_totals(logic [3:0] f, logic [7:0] idx,
                                             logic [7:0] amt);
    int unsigned total;
    totals_t     t;
    total = 0;
    case (f)
      F_DEC_ONE: if (idx < NUM_CH) chan_level[idx] = chan_level[idx] - amt;
      F_INC_ONE: if (idx < NUM_CH) chan_level[idx] = chan_level[idx] + amt;
      F_SET_ONE: if (idx < NUM_CH) chan_level[idx] = amt;
      F_SET_ALL: sweep_levels(GRP_ALL, K_SET, amt);
      F_SET_CMD: sweep_levels(GRP_CMD, K_SET, amt);
      F_SET_STO: sweep_levels(GRP_STO, K_SET, amt);
      F_DEC_ALL: sweep_levels(GRP_ALL, K_SUB, amt);
      F_INC_ALL: sweep_levels(GRP_ALL, K_ADD, amt);
      F_DEC_STO: sweep_levels(GRP_STO, K_SUB, amt);
      F_INC_STO: sweep_levels(GRP_STO, K_ADD, amt);
      F_DEC_CMD: sweep_levels(GRP_CMD, K_SUB, amt);
      F_INC_CMD: sweep_levels(GRP_CMD, K_ADD, amt);
      F_LD_CMD:  if (idx < NUM_MB) cmd_mask_copy[idx] = amt;
      F_LD_STO:  if (idx < NUM_MB) sto_mask_copy[idx] = amt;
      default: ;
    endcase
    foreach (chan_level[ch]) total += chan_level[ch];
    total = total & 32'hFFFF;
    t.sum = total[SUM_W-1:0];
    t.cur = CUR_W'((total * MA_NUM) / MA_DEN);
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // valid is only dropped for a gap, so back-to-back words never toggle it
  task automatic send_cmd(logic [3:0] f, logic [7:0] idx, logic [7:0] amt);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, amt, idx, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_totals.push_back(predict_totals(f, idx, amt));
    n_sent++;
    op_hits[f]++;
  endtask

  task automatic send_random_cmd();
    int         pick;
    logic [3:0] f;
    logic [7:0] idx;
    logic [7:0] amt;
    pick = $urandom_range(0, 99);
    idx  = 8'($urandom_range(0, 255));
    amt  = 8'($urandom_range(0, 255));
    if (pick < 35) begin
      f = 4'($urandom_range(F_DEC_ONE, F_SET_ONE));
      if ($urandom_range(0, 9) != 0) idx = 8'($urandom_range(0, NUM_CH - 1));
    end else if (pick < 55) begin
      f = ($urandom_range(0, 1) != 0) ? F_LD_CMD : F_LD_STO;
      if ($urandom_range(0, 9) != 0) idx = 8'($urandom_range(0, NUM_MB - 1));
      // dense and empty mask bytes now and then
      if ($urandom_range(0, 4) == 0) amt = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    end else if (pick < 97) begin
      f = 4'($urandom_range(F_SET_ALL, F_INC_CMD));
    end else begin
      f = 4'($urandom_range(F_SPARE_LO, F_SPARE_HI));
    end
    send_cmd(f, idx, amt);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall  <= out_stall - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    totals_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_totals.size() == 0) begin
        $error("result word with no command pending: %h", out_tdata);
        n_errors++;
      end else begin
        want = pending_totals.pop_front();
        if (out_tdata[15:0] !== want.sum) begin
          $error("brightness_sum: expected %0d, got %0d", want.sum, out_tdata[15:0]);
          n_errors++;
        end
        if (out_tdata[25:16] !== want.cur) begin
          $error("current_estimate: expected %0d, got %0d", want.cur, out_tdata[25:16]);
          n_errors++;
        end
        n_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_single_channel();
    send_cmd(F_SET_ONE, 8'd0,   8'hFF);
    send_cmd(F_INC_ONE, 8'd0,   8'h01);   // wraps to zero
    send_cmd(F_DEC_ONE, 8'd143, 8'h01);   // wraps to 255
    send_cmd(F_SET_ONE, 8'd143, 8'h00);
    send_cmd(F_DEC_ONE, 8'd144, 8'h55);   // first channel past the end
    send_cmd(F_INC_ONE, 8'd255, 8'hAA);
  endtask

  task automatic test_whole_buffer();
    send_cmd(F_SET_ALL, 8'd0, 8'hAA);
    send_cmd(F_INC_ALL, 8'd0, 8'h56);     // every channel wraps to zero
    send_cmd(F_DEC_ALL, 8'd0, 8'h01);     // full-scale sum
  endtask

  task automatic test_mask_commands();
    send_cmd(F_LD_CMD,  8'd0,   8'hFF);
    send_cmd(F_LD_CMD,  8'd17,  8'h81);
    send_cmd(F_LD_CMD,  8'd18,  8'hFF);   // mask byte past the end
    send_cmd(F_LD_STO,  8'd5,   8'h0F);
    send_cmd(F_LD_STO,  8'd255, 8'hFF);
    send_cmd(F_SET_CMD, 8'd0,   8'h10);
    send_cmd(F_INC_CMD, 8'd0,   8'hFF);
    send_cmd(F_DEC_CMD, 8'd0,   8'h20);
    send_cmd(F_SET_STO, 8'd0,   8'h00);
    send_cmd(F_INC_STO, 8'd0,   8'h07);
    send_cmd(F_DEC_STO, 8'd0,   8'hFF);
  endtask

  task automatic test_unused_codes();
    send_cmd(F_SPARE_LO, 8'd3,   8'h33);
    send_cmd(F_SPARE_HI, 8'hFF,  8'hFF);
  endtask

  task automatic test_random_traffic(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      send_random_cmd();
    end
  endtask

  task automatic test_streaming(int n);
    idle_on = 1'b0;
    for (int i = 0; i < n; i++) send_random_cmd();
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (pending_totals.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_totals.size() != 0) begin
      $error("%0d result words never arrived", pending_totals.size());
      n_errors++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n_codes;
    clear_levels();
    idle_on = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_channel();
    test_whole_buffer();
    test_mask_commands();
    test_unused_codes();
    test_random_traffic(1700);
    test_streaming(250);
    wait_drained();

    n_codes = 0;
    foreach (op_hits[i]) if (op_hits[i] != 0) n_codes++;
    $display("%0d commands over %0d of 16 function codes, %0d result words checked",
             n_sent, n_codes, n_checked);
    $display("single, whole-buffer, masked and mask-load updates with wrap-around");
    if (n_errors == 0) begin
      $display("PASS led_pwm_buffer_update_engine");
    end else begin
      $display("FAIL led_pwm_buffer_update_engine");
    end
    $finish;
  end

  // generous cap: several times the slowest legal run
  initial begin
    #20ms;
    $display("FAIL led_pwm_buffer_update_engine");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/lpbue_pkg.sv
hdl/lpbue_ram.sv
hdl/lpbue_front.sv
hdl/lpbue_queue.sv
hdl/lpbue_back.sv
hdl/led_pwm_buffer_update_engine.sv
test/led_pwm_buffer_update_engine_tb.sv
